/* sv/aeration_pump_cycle_timer_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the aeration pump cycle timer
// Concurrent checks on clk, disabled while rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef AERATION_PUMP_CYCLE_TIMER_MACROS_SVH
`define AERATION_PUMP_CYCLE_TIMER_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define APCT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define APCT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define APCT_ASSERT_IMP(lbl, ante, cons, msg)
`define APCT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/apct_pkg.sv */
// ----------------------------------------------------------------------------
// apct_pkg
// Word types, request, mode and pump phase codes, and register map of the
// aeration pump cycle timer.
// ----------------------------------------------------------------------------
package apct_pkg;

    localparam logic [1:0] REQ_TICK      = 2'd0;
    localparam logic [1:0] REQ_AIR_START = 2'd1;
    localparam logic [1:0] REQ_PUMP_INIT = 2'd2;

    localparam logic [1:0] MODE_OTHER  = 2'd0;
    localparam logic [1:0] MODE_AIR    = 2'd1;
    localparam logic [1:0] MODE_CIRC   = 2'd2;
    localparam logic [1:0] MODE_MANUAL = 2'd3;

    localparam logic [1:0] PUMP_DISABLED = 2'd0;
    localparam logic [1:0] PUMP_OFF      = 2'd1;
    localparam logic [1:0] PUMP_ON       = 2'd2;

    localparam logic [5:0] SEC_PER_MIN    = 6'd60;
    localparam logic [7:0] MIN_PER_HOUR   = 8'd60;
    localparam logic [5:0] PUMP_RELOAD_S  = 6'd2;

    // register indexes (byte address = 4 * index)
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_AIR_ON     = 3'd0;
    localparam logic [2:0] REG_AIR_OFF    = 3'd1;
    localparam logic [2:0] REG_CIRC_ON    = 3'd2;
    localparam logic [2:0] REG_CIRC_OFF   = 3'd3;
    localparam logic [2:0] REG_PUMP_ON    = 3'd4;
    localparam logic [2:0] REG_PUMP_OFF_H = 3'd5;
    localparam logic [2:0] REG_PUMP_OFF_M = 3'd6;

    localparam logic [7:0] RST_AIR_ON     = 8'd30;
    localparam logic [7:0] RST_AIR_OFF    = 8'd30;
    localparam logic [7:0] RST_CIRC_ON    = 8'd5;
    localparam logic [7:0] RST_CIRC_OFF   = 8'd25;
    localparam logic [7:0] RST_PUMP_ON    = 8'd10;
    localparam logic [7:0] RST_PUMP_OFF_H = 8'd1;
    localparam logic [7:0] RST_PUMP_OFF_M = 8'd0;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] plant_mode;
        logic       error_active;
    } in_word_t;

    typedef struct packed {
        logic       air_drive;
        logic       pump_drive;
        logic       air_phase_on;
        logic [7:0] air_minutes_left;
        logic [5:0] air_seconds_left;
        logic [1:0] pump_phase;
        logic [7:0] pump_hours_left;
        logic [7:0] pump_minutes_left;
        logic [5:0] pump_seconds_left;
    } out_word_t;

endpackage

/* sv/aeration_pump_cycle_timer.sv */
// ----------------------------------------------------------------------------
// aeration_pump_cycle_timer
// Air and inflow pump duty-cycle timers driven by second ticks and start words.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid / in_stall / in_data, one request word each
//                 (second tick, start air phase, pump init).
//   out channel : out_valid / out_stall / out_data, one status word for every
//                 request word, giving drives, phases and remaining times.
//   APB port    : seven 8-bit time registers at byte address 4*index; write
//                 only while no word is in flight. pready is tied high.
// Each status word is registered; throughput is one word per cycle while
// in_stall is low. The timer update is a single pass over the state
// registers, and the output holds a main register and a skid register so a
// word is still taken in the cycle the receiver first stalls. in_stall rises
// only when both output registers are full.
// Reset clears the timers (pump phase off), loads the default register
// values and empties the output registers.
// ----------------------------------------------------------------------------
`include "aeration_pump_cycle_timer_macros.svh"

module aeration_pump_cycle_timer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  apct_pkg::in_word_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output apct_pkg::out_word_t                 out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [apct_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    // configuration registers
    logic [7:0] air_on_min_reg, air_off_min_reg, circ_on_min_reg, circ_off_min_reg;
    logic [7:0] pump_on_min_reg, pump_off_h_reg, pump_off_min_reg;

    // timer state
    logic       air_phase_reg, air_phase_next;
    logic [7:0] air_min_reg, air_min_next;
    logic [5:0] air_sec_reg, air_sec_next;
    logic       air_out_reg, air_out_next;
    logic [1:0] pump_mode_reg, pump_mode_next;
    logic [7:0] pump_h_reg, pump_h_next;
    logic [7:0] pump_min_reg, pump_min_next;
    logic [5:0] pump_sec_reg, pump_sec_next;
    logic       pump_out_reg, pump_out_next;
    logic       pump_started_reg, pump_started_next;

    // output buffer
    apct_pkg::out_word_t main_reg, skid_reg, result;
    logic                main_valid_reg, skid_valid_reg;

    logic       accept, take, cfg_write, pump_follows;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign take      = main_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            air_on_min_reg   <= apct_pkg::RST_AIR_ON;
            air_off_min_reg  <= apct_pkg::RST_AIR_OFF;
            circ_on_min_reg  <= apct_pkg::RST_CIRC_ON;
            circ_off_min_reg <= apct_pkg::RST_CIRC_OFF;
            pump_on_min_reg  <= apct_pkg::RST_PUMP_ON;
            pump_off_h_reg   <= apct_pkg::RST_PUMP_OFF_H;
            pump_off_min_reg <= apct_pkg::RST_PUMP_OFF_M;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                apct_pkg::REG_AIR_ON:     air_on_min_reg   <= pwdata[7:0];
                apct_pkg::REG_AIR_OFF:    air_off_min_reg  <= pwdata[7:0];
                apct_pkg::REG_CIRC_ON:    circ_on_min_reg  <= pwdata[7:0];
                apct_pkg::REG_CIRC_OFF:   circ_off_min_reg <= pwdata[7:0];
                apct_pkg::REG_PUMP_ON:    pump_on_min_reg  <= pwdata[7:0];
                apct_pkg::REG_PUMP_OFF_H: pump_off_h_reg   <= pwdata[7:0];
                apct_pkg::REG_PUMP_OFF_M: pump_off_min_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            apct_pkg::REG_AIR_ON:     prdata = {24'd0, air_on_min_reg};
            apct_pkg::REG_AIR_OFF:    prdata = {24'd0, air_off_min_reg};
            apct_pkg::REG_CIRC_ON:    prdata = {24'd0, circ_on_min_reg};
            apct_pkg::REG_CIRC_OFF:   prdata = {24'd0, circ_off_min_reg};
            apct_pkg::REG_PUMP_ON:    prdata = {24'd0, pump_on_min_reg};
            apct_pkg::REG_PUMP_OFF_H: prdata = {24'd0, pump_off_h_reg};
            apct_pkg::REG_PUMP_OFF_M: prdata = {24'd0, pump_off_min_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // timer update for one request word
    always_comb
    begin
        air_phase_next    = air_phase_reg;
        air_min_next      = air_min_reg;
        air_sec_next      = air_sec_reg;
        air_out_next      = air_out_reg;
        pump_mode_next    = pump_mode_reg;
        pump_h_next       = pump_h_reg;
        pump_min_next     = pump_min_reg;
        pump_sec_next     = pump_sec_reg;
        pump_out_next     = pump_out_reg;
        pump_started_next = pump_started_reg;
        pump_follows      = (pump_mode_reg == apct_pkg::PUMP_ON) &&
                            (in_data.plant_mode != apct_pkg::MODE_MANUAL);

        case (in_data.req_type)
            apct_pkg::REQ_TICK:
            begin
                if (in_data.plant_mode inside {apct_pkg::MODE_AIR, apct_pkg::MODE_CIRC,
                                               apct_pkg::MODE_MANUAL})
                begin
                    if (air_sec_next == 6'd0 && !in_data.error_active)
                    begin
                        air_sec_next = apct_pkg::SEC_PER_MIN;
                        if (air_min_next != 8'd0)
                            air_min_next = air_min_next - 8'd1;
                    end
                    if (air_sec_next != 6'd0)
                        air_sec_next = air_sec_next - 6'd1;
                    // toggle the phase even with an error pending
                    if (air_min_next == 8'd0 && air_sec_next == 6'd0)
                    begin
                        if (air_phase_reg)
                        begin
                            air_out_next   = 1'b0;
                            if (pump_follows)
                                pump_out_next = 1'b1;
                            air_phase_next = 1'b0;
                            air_min_next   = (in_data.plant_mode == apct_pkg::MODE_AIR) ?
                                             air_off_min_reg : circ_off_min_reg;
                        end
                        else
                        begin
                            if (pump_follows)
                                pump_out_next = 1'b0;
                            air_out_next   = 1'b1;
                            air_phase_next = 1'b1;
                            air_min_next   = (in_data.plant_mode == apct_pkg::MODE_AIR) ?
                                             air_on_min_reg : circ_on_min_reg;
                        end
                    end
                end

                // pump part sees the air phase as left above
                if (pump_mode_reg != apct_pkg::PUMP_DISABLED &&
                    (in_data.plant_mode == apct_pkg::MODE_AIR ||
                     in_data.plant_mode == apct_pkg::MODE_CIRC) &&
                    !(air_phase_next && pump_mode_reg == apct_pkg::PUMP_ON))
                begin
                    if (pump_sec_next == 6'd0)
                    begin
                        if (pump_min_next != 8'd0 || pump_h_next != 8'd0)
                            pump_sec_next = apct_pkg::SEC_PER_MIN;
                        if (pump_min_next == 8'd0 && pump_h_next != 8'd0)
                        begin
                            pump_min_next = apct_pkg::MIN_PER_HOUR;
                            pump_h_next   = pump_h_next - 8'd1;
                        end
                        if (pump_min_next != 8'd0)
                            pump_min_next = pump_min_next - 8'd1;
                    end
                    if (pump_sec_next != 6'd0)
                        pump_sec_next = pump_sec_next - 6'd1;
                    if (pump_h_next == 8'd0 && pump_min_next == 8'd0 &&
                        pump_sec_next == 6'd0 && !in_data.error_active)
                    begin
                        // the unused phase code counts as off
                        if (pump_mode_reg == apct_pkg::PUMP_ON)
                        begin
                            pump_mode_next = apct_pkg::PUMP_OFF;
                            pump_h_next    = pump_off_h_reg;
                            pump_min_next  = pump_off_min_reg;
                            pump_out_next  = 1'b0;
                        end
                        else
                        begin
                            pump_mode_next = apct_pkg::PUMP_ON;
                            pump_h_next    = 8'd0;
                            pump_min_next  = pump_on_min_reg;
                            pump_out_next  = 1'b1;
                        end
                        pump_sec_next = apct_pkg::PUMP_RELOAD_S;
                    end
                end
            end
            apct_pkg::REQ_AIR_START:
            begin
                air_phase_next = 1'b1;
                air_min_next   = (in_data.plant_mode == apct_pkg::MODE_AIR) ?
                                 air_on_min_reg : circ_on_min_reg;
                air_sec_next   = 6'd0;
            end
            apct_pkg::REQ_PUMP_INIT:
            begin
                if (!pump_started_reg)
                begin
                    pump_h_next = 8'd0;
                    if (pump_on_min_reg == 8'd0)
                    begin
                        pump_min_next  = 8'd0;
                        pump_sec_next  = 6'd0;
                        pump_mode_next = apct_pkg::PUMP_DISABLED;
                    end
                    else
                    begin
                        pump_min_next  = 8'd1;
                        pump_sec_next  = apct_pkg::PUMP_RELOAD_S;
                        pump_mode_next = apct_pkg::PUMP_OFF;
                    end
                    pump_started_next = 1'b1;
                end
            end
            default: ;
        endcase

        result.air_drive         = air_out_next;
        result.pump_drive        = pump_out_next;
        result.air_phase_on      = air_phase_next;
        result.air_minutes_left  = air_min_next;
        result.air_seconds_left  = air_sec_next;
        result.pump_phase        = pump_mode_next;
        result.pump_hours_left   = pump_h_next;
        result.pump_minutes_left = pump_min_next;
        result.pump_seconds_left = pump_sec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            air_phase_reg    <= 1'b0;
            air_min_reg      <= 8'd0;
            air_sec_reg      <= 6'd0;
            air_out_reg      <= 1'b0;
            pump_mode_reg    <= apct_pkg::PUMP_OFF;
            pump_h_reg       <= 8'd0;
            pump_min_reg     <= 8'd0;
            pump_sec_reg     <= 6'd0;
            pump_out_reg     <= 1'b0;
            pump_started_reg <= 1'b0;
        end
        else if (accept)
        begin
            air_phase_reg    <= air_phase_next;
            air_min_reg      <= air_min_next;
            air_sec_reg      <= air_sec_next;
            air_out_reg      <= air_out_next;
            pump_mode_reg    <= pump_mode_next;
            pump_h_reg       <= pump_h_next;
            pump_min_reg     <= pump_min_next;
            pump_sec_reg     <= pump_sec_next;
            pump_out_reg     <= pump_out_next;
            pump_started_reg <= pump_started_next;
        end
    end

    // main register feeds the port; skid catches a word while main is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!main_valid_reg || take)
            begin
                if (skid_valid_reg)
                begin
                    main_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    main_valid_reg <= accept;
                end
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || take)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (accept)
                main_reg <= result;
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

    `APCT_ASSERT_IMP(a_skid_needs_main, skid_valid_reg, main_valid_reg, "skid full with main empty")
    `APCT_ASSERT_NXT(a_stalled_accept_fills_skid, accept && main_valid_reg && !take, skid_valid_reg, "word lost while output stalled")
    `APCT_ASSERT_NXT(a_pump_started_holds, pump_started_reg, pump_started_reg, "pump init flag cleared")
    `APCT_ASSERT_IMP(a_seconds_range, 1'b1, air_sec_reg <= apct_pkg::SEC_PER_MIN && pump_sec_reg <= apct_pkg::SEC_PER_MIN, "seconds above one minute")

endmodule
